FILE: rtl/istka_pkg.sv
// Shared types and constants of the impact score top-K accumulator.
`timescale 1ns / 1ps

package istka_pkg;

    localparam int TOP_K_DEF     = 15;
    localparam int DOC_COUNT_DEF = 65536;
    localparam int KIND_W        = 2;
    localparam int DOC_W         = 16;
    localparam int IMP_W         = 8;
    localparam int SCORE_W       = 16;
    localparam int RANK_W        = 4;
    localparam int MAX_OUT       = 15;
    localparam int EPOCH_W       = 8;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POST  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [DOC_W-1:0] doc_id;
        logic [IMP_W-1:0] impact;
    } t_cmd;

    typedef struct packed {
        logic               clr;
        logic               ins;
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
    } t_list_cmd;

endpackage

FILE: rtl/istka_front.sv
// Front end: accepts input words, drops those with no effect and queues the rest.
`timescale 1ns / 1ps

module istka_front #(
    parameter int DOC_COUNT = istka_pkg::DOC_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [istka_pkg::KIND_W-1:0] i_kind,
    input  logic [istka_pkg::DOC_W-1:0]  i_doc_id,
    input  logic [istka_pkg::IMP_W-1:0]  i_impact,
    output logic                        o_q_valid,
    output istka_pkg::t_cmd             o_q_cmd,
    input  logic                        i_q_pop
);
    import istka_pkg::*;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_cmd           r_q [QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           keep;
    logic           push;
    t_cmd           cmd;

    always_comb begin
        cmd.doc_id = i_doc_id;
        cmd.impact = i_impact;
        cmd.op     = OP_CLEAR;
        keep       = 1'b0;
        unique case (i_kind)
            KIND_CLEAR: begin
                cmd.op = OP_CLEAR;
                keep   = 1'b1;
            end
            KIND_POST: begin
                // A posting beyond the document range leaves no trace.
                cmd.op = OP_POST;
                keep   = (32'(i_doc_id) < 32'(DOC_COUNT));
            end
            KIND_READ: begin
                cmd.op = OP_READ;
                keep   = 1'b1;
            end
            default: begin
                cmd.op = OP_CLEAR;
                keep   = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_count == QCW'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall && keep;
    assign o_q_valid  = (r_count != '0);
    assign o_q_cmd    = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (!push && i_q_pop) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

endmodule

FILE: rtl/istka_list.sv
// Sorted top-K list held in a row of slots that all update at once.
`timescale 1ns / 1ps

module istka_list #(
    parameter int  TOP_K = istka_pkg::TOP_K_DEF,
    localparam int IdxW  = (TOP_K > 1) ? $clog2(TOP_K) : 1,
    localparam int CntW  = $clog2(TOP_K + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  istka_pkg::t_list_cmd          i_cmd,
    input  logic [IdxW-1:0]               i_rd_idx,
    output logic [istka_pkg::DOC_W-1:0]   o_rd_doc,
    output logic [istka_pkg::SCORE_W-1:0] o_rd_score,
    output logic [CntW-1:0]               o_cnt
);
    import istka_pkg::*;

    typedef enum logic [1:0] {
        SEL_KEEP = 2'd0,
        SEL_UP   = 2'd1,
        SEL_DOWN = 2'd2,
        SEL_NEW  = 2'd3
    } t_sel;

    logic [DOC_W-1:0]   r_doc   [TOP_K];
    logic [SCORE_W-1:0] r_score [TOP_K];
    logic [CntW-1:0]    r_cnt;

    logic [TOP_K-1:0]   match;
    logic [TOP_K+1:0]   ge_pad;   // ge_pad[j+1] is "slot j holds a score at least the new one"
    logic               found;
    logic               ahead;    // the listed copy sits among the entries that stay ahead
    logic [IdxW-1:0]    m_idx;

    always_comb begin
        ge_pad[0]         = 1'b1;
        ge_pad[TOP_K+1]   = 1'b0;
        found             = 1'b0;
        ahead             = 1'b0;
        m_idx             = '0;
        for (int j = 0; j < TOP_K; j++) begin
            match[j]    = (CntW'(j) < r_cnt) && (r_doc[j] == i_cmd.doc);
            ge_pad[j+1] = (CntW'(j) < r_cnt) && (r_score[j] >= i_cmd.score);
            found       = found | match[j];
            ahead       = ahead | (match[j] & ge_pad[j+1]);
            m_idx       = m_idx | (match[j] ? IdxW'(j) : '0);
        end
    end

    for (genvar j = 0; j < TOP_K; j++) begin : g_slot
        logic [DOC_W-1:0]   up_doc, dn_doc;
        logic [SCORE_W-1:0] up_score, dn_score;
        logic               at_m, past_m;
        t_sel               sel;

        if (j == 0) begin : g_first
            assign dn_doc   = '0;
            assign dn_score = '0;
        end else begin : g_mid_dn
            assign dn_doc   = r_doc[j-1];
            assign dn_score = r_score[j-1];
        end
        if (j == TOP_K - 1) begin : g_last
            assign up_doc   = '0;
            assign up_score = '0;
        end else begin : g_mid_up
            assign up_doc   = r_doc[j+1];
            assign up_score = r_score[j+1];
        end

        assign at_m   = found && (IdxW'(j) >= m_idx);
        assign past_m = found && (IdxW'(j) > m_idx);

        // The new entry lands after every remaining entry with a score at least as high.
        always_comb begin
            if (ahead) begin
                priority if (!at_m) begin
                    sel = SEL_KEEP;
                end else if (ge_pad[j+2]) begin
                    sel = SEL_UP;
                end else if (ge_pad[j+1]) begin
                    sel = SEL_NEW;
                end else begin
                    sel = SEL_KEEP;
                end
            end else begin
                priority if (ge_pad[j+1]) begin
                    sel = SEL_KEEP;
                end else if (ge_pad[j]) begin
                    sel = SEL_NEW;
                end else if (past_m) begin
                    sel = SEL_KEEP;
                end else begin
                    sel = SEL_DOWN;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.ins) begin
                unique case (sel)
                    SEL_KEEP: begin
                        r_doc[j]   <= r_doc[j];
                        r_score[j] <= r_score[j];
                    end
                    SEL_UP: begin
                        r_doc[j]   <= up_doc;
                        r_score[j] <= up_score;
                    end
                    SEL_DOWN: begin
                        r_doc[j]   <= dn_doc;
                        r_score[j] <= dn_score;
                    end
                    SEL_NEW: begin
                        r_doc[j]   <= i_cmd.doc;
                        r_score[j] <= i_cmd.score;
                    end
                    default: begin
                        r_doc[j]   <= r_doc[j];
                        r_score[j] <= r_score[j];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_cnt <= '0;
        end else if (i_cmd.ins && !found && (r_cnt != CntW'(TOP_K))) begin
            r_cnt <= r_cnt + CntW'(1);
        end
    end

    assign o_rd_doc   = r_doc[i_rd_idx];
    assign o_rd_score = r_score[i_rd_idx];
    assign o_cnt      = r_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(TOP_K))
        else $error("list fill count exceeds its depth");

    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |=> (r_cnt == '0))
        else $error("list not empty after a clear");

    a_new_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && !i_cmd.clr && !found && (r_cnt < CntW'(TOP_K)))
        |=> (r_cnt == $past(r_cnt) + CntW'(1)))
        else $error("new document did not lengthen a list with room");

    a_relist_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && !i_cmd.clr && found) |=> $stable(r_cnt))
        else $error("re-listed document changed the list length");

endmodule

FILE: rtl/istka_back.sv
// Back end: sequencer, per-document score memory and the readout output register.
`timescale 1ns / 1ps

module istka_back #(
    parameter int  TOP_K     = istka_pkg::TOP_K_DEF,
    parameter int  DOC_COUNT = istka_pkg::DOC_COUNT_DEF,
    localparam int IdxW      = (TOP_K > 1) ? $clog2(TOP_K) : 1,
    localparam int CntW      = $clog2(TOP_K + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  istka_pkg::t_cmd               i_q_cmd,
    output logic                          o_q_pop,
    output istka_pkg::t_list_cmd          o_list_cmd,
    output logic [IdxW-1:0]               o_rd_idx,
    input  logic [istka_pkg::DOC_W-1:0]   i_rd_doc,
    input  logic [istka_pkg::SCORE_W-1:0] i_rd_score,
    input  logic [CntW-1:0]               i_list_cnt,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [istka_pkg::RANK_W-1:0]  o_rank,
    output logic [istka_pkg::DOC_W-1:0]   o_ranked_doc,
    output logic [istka_pkg::SCORE_W-1:0] o_ranked_score,
    output logic                          o_entry_valid,
    output logic                          o_last
);
    import istka_pkg::*;

    localparam int DocAw = $clog2(DOC_COUNT);
    localparam int MemW  = EPOCH_W + SCORE_W;
    localparam int CmpW  = ((CntW > RANK_W) ? CntW : RANK_W) + 1;

    typedef enum logic [4:0] {
        S_WIPE = 5'b00001,
        S_IDLE = 5'b00010,
        S_ADD  = 5'b00100,
        S_INS  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [DocAw-1:0]    r_wipe;
    logic [RANK_W-1:0]   r_idx;
    logic [DocAw-1:0]    r_doc_a;
    logic [DOC_W-1:0]    r_doc;
    logic [IMP_W-1:0]    r_imp;
    logic [SCORE_W-1:0]  r_sum;

    // Each score word carries the epoch of the query that wrote it.
    logic [MemW-1:0]     r_score_mem [DOC_COUNT];
    logic [MemW-1:0]     r_mem_q;

    logic                r_o_valid;
    logic [RANK_W-1:0]   r_o_rank;
    logic [DOC_W-1:0]    r_o_doc;
    logic [SCORE_W-1:0]  r_o_score;
    logic                r_o_entry;
    logic                r_o_last;

    logic                take;
    logic                mem_re, mem_we;
    logic [DocAw-1:0]    mem_wa;
    logic [MemW-1:0]     mem_wd;
    logic [SCORE_W-1:0]  old_score;
    logic [SCORE_W:0]    sum_wide;
    logic [SCORE_W-1:0]  sum_sat;
    logic                out_load;
    logic                empty;
    logic                last_entry;

    assign take = i_q_valid
        && ((r_state == S_IDLE) || ((r_state == S_INS) && (i_q_cmd.op == OP_POST)));
    assign o_q_pop = take;

    assign old_score = (r_mem_q[MemW-1:SCORE_W] == r_epoch) ? r_mem_q[SCORE_W-1:0] : '0;
    assign sum_wide  = {1'b0, old_score} + (SCORE_W+1)'(r_imp);
    assign sum_sat   = sum_wide[SCORE_W] ? '1 : sum_wide[SCORE_W-1:0];

    assign mem_re = take && (i_q_cmd.op == OP_POST);
    assign mem_we = (r_state == S_ADD) || (r_state == S_WIPE);
    assign mem_wa = (r_state == S_WIPE) ? r_wipe : r_doc_a;
    assign mem_wd = (r_state == S_WIPE) ? {r_epoch, SCORE_W'(0)} : {r_epoch, sum_sat};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_score_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_score_mem[DocAw'(i_q_cmd.doc_id)];
        end
    end

    always_comb begin
        o_list_cmd.clr   = take && (i_q_cmd.op == OP_CLEAR);
        o_list_cmd.ins   = (r_state == S_INS);
        o_list_cmd.doc   = r_doc;
        o_list_cmd.score = r_sum;
    end

    assign o_rd_idx   = IdxW'(r_idx);
    assign empty      = (i_list_cnt == '0);
    assign last_entry = empty || (r_idx == RANK_W'(MAX_OUT - 1))
        || ((CmpW'(r_idx) + CmpW'(1)) == CmpW'(i_list_cnt));
    assign out_load   = (r_state == S_OUT) && (!r_o_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WIPE: begin
                if (r_wipe == DocAw'(DOC_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_INS: begin
                n_state = S_IDLE;
                if (take) begin
                    unique case (i_q_cmd.op)
                        OP_CLEAR: n_state = (r_epoch == '1) ? S_WIPE : S_IDLE;
                        OP_POST:  n_state = S_ADD;
                        OP_READ:  n_state = S_OUT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                n_state = S_INS;
            end
            S_OUT: begin
                if (out_load && last_entry) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_WIPE;
            r_epoch   <= '0;
            r_wipe    <= '0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WIPE) begin
                r_wipe <= r_wipe + DocAw'(1);
            end
            if (take && (i_q_cmd.op == OP_CLEAR)) begin
                // Moving to a new epoch retires every stored score at once.
                r_epoch <= r_epoch + EPOCH_W'(1);
                r_wipe  <= '0;
            end
            if (take && (i_q_cmd.op == OP_READ)) begin
                r_idx <= '0;
            end else if (out_load) begin
                r_idx <= r_idx + RANK_W'(1);
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_doc_a <= DocAw'(i_q_cmd.doc_id);
            r_doc   <= i_q_cmd.doc_id;
            r_imp   <= i_q_cmd.impact;
        end
        if (r_state == S_ADD) begin
            r_sum <= sum_sat;
        end
        if (out_load) begin
            r_o_rank  <= empty ? '0 : r_idx;
            r_o_doc   <= empty ? '0 : i_rd_doc;
            r_o_score <= empty ? '0 : i_rd_score;
            r_o_entry <= !empty;
            r_o_last  <= last_entry;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_rank         = r_o_rank;
    assign o_ranked_doc   = r_o_doc;
    assign o_ranked_score = r_o_score;
    assign o_entry_valid  = r_o_entry;
    assign o_last         = r_o_last;

endmodule

FILE: rtl/impact_score_topk_accumulator.sv
// Top level of the impact score top-K accumulator.
`timescale 1ns / 1ps

// Accumulates posting impacts per document for one query and keeps the TOP_K best
// documents sorted, highest score first, ties in order of arrival. After reset, and
// after every 2**8 clears, the score memory is swept once, one word a cycle, while
// input words only fill the two-word queue. A posting first reads the score memory,
// then adds and writes back, with the list update overlapping the read of the next
// posting. A readout gives one word per cycle while the output is not stalled, at
// most 15 words, through an output register that lets the front end keep accepting
// while a result waits.
module impact_score_topk_accumulator #(
    parameter int TOP_K     = istka_pkg::TOP_K_DEF,
    parameter int DOC_COUNT = istka_pkg::DOC_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [istka_pkg::KIND_W-1:0]  i_kind,
    input  logic [istka_pkg::DOC_W-1:0]   i_doc_id,
    input  logic [istka_pkg::IMP_W-1:0]   i_impact,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [istka_pkg::RANK_W-1:0]  o_rank,
    output logic [istka_pkg::DOC_W-1:0]   o_ranked_doc,
    output logic [istka_pkg::SCORE_W-1:0] o_ranked_score,
    output logic                          o_entry_valid,
    output logic                          o_last
);
    import istka_pkg::*;

    localparam int IdxW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int CntW = $clog2(TOP_K + 1);

    logic               q_valid;
    t_cmd               q_cmd;
    logic               q_pop;
    t_list_cmd          list_cmd;
    logic [IdxW-1:0]    rd_idx;
    logic [DOC_W-1:0]   rd_doc;
    logic [SCORE_W-1:0] rd_score;
    logic [CntW-1:0]    list_cnt;

    istka_front #(
        .DOC_COUNT (DOC_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_doc_id   (i_doc_id),
        .i_impact   (i_impact),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    istka_list #(
        .TOP_K (TOP_K)
    ) u_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (list_cmd),
        .i_rd_idx   (rd_idx),
        .o_rd_doc   (rd_doc),
        .o_rd_score (rd_score),
        .o_cnt      (list_cnt)
    );

    istka_back #(
        .TOP_K     (TOP_K),
        .DOC_COUNT (DOC_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_cmd        (q_cmd),
        .o_q_pop        (q_pop),
        .o_list_cmd     (list_cmd),
        .o_rd_idx       (rd_idx),
        .i_rd_doc       (rd_doc),
        .i_rd_score     (rd_score),
        .i_list_cnt     (list_cnt),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rank         (o_rank),
        .o_ranked_doc   (o_ranked_doc),
        .o_ranked_score (o_ranked_score),
        .o_entry_valid  (o_entry_valid),
        .o_last         (o_last)
    );

endmodule

FILE: verif/impact_score_topk_accumulator_tb.sv
// Self-checking testbench for the impact score top-K accumulator.
`timescale 1ns / 1ps

module impact_score_topk_accumulator_tb;

    import istka_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    // After reset the score memory is swept while only the input queue accepts words.
    localparam int IDLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_WORDS = 125;
    localparam int CALM_WORDS = 100;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
        logic               filled;
        logic               last;
    } t_ranked_word;

    class ranking_scoreboard;
        logic [SCORE_W-1:0] doc_totals [int unsigned];
        logic [DOC_W-1:0]   list_doc [TOP_K_DEF];
        logic [SCORE_W-1:0] list_score [TOP_K_DEF];
        int                 list_len;
        t_ranked_word       pending_ranks [$];
        int                 mismatch_count;

        function void wipe_query();
            doc_totals.delete();
            list_len = 0;
            for (int i = 0; i < TOP_K_DEF; i++) begin
                list_doc[i] = '0;
                list_score[i] = '0;
            end
        endfunction

        function void add_posting(logic [DOC_W-1:0] doc, logic [IMP_W-1:0] imp);
            int unsigned total;
            int hit;
            int pos;
            total = (doc_totals.exists(doc) ? int'(doc_totals[doc]) : 0) + imp;
            if (total > 32'hFFFF) begin
                total = 32'hFFFF;
            end
            doc_totals[doc] = SCORE_W'(total);
            hit = -1;
            for (int i = 0; i < list_len; i++) begin
                if (hit < 0 && list_doc[i] == doc) begin
                    hit = i;
                end
            end
            // A listed document always leaves the list before it is placed again.
            if (hit >= 0) begin
                for (int i = hit; i + 1 < list_len; i++) begin
                    list_doc[i] = list_doc[i + 1];
                    list_score[i] = list_score[i + 1];
                end
                list_len--;
                list_doc[list_len] = '0;
                list_score[list_len] = '0;
            end
            if (list_len == TOP_K_DEF && total <= list_score[TOP_K_DEF - 1]) begin
                return;
            end
            pos = 0;
            while (pos < list_len && list_score[pos] >= total) begin
                pos++;
            end
            if (list_len == TOP_K_DEF) begin
                list_len = TOP_K_DEF - 1;
            end
            for (int i = list_len; i > pos; i--) begin
                list_doc[i] = list_doc[i - 1];
                list_score[i] = list_score[i - 1];
            end
            list_doc[pos] = doc;
            list_score[pos] = SCORE_W'(total);
            list_len++;
        endfunction

        function void absorb_word(logic [KIND_W-1:0] kind, logic [DOC_W-1:0] doc,
                                  logic [IMP_W-1:0] imp);
            t_ranked_word w;
            int n;
            if (kind == OP_CLEAR) begin
                wipe_query();
            end else if (kind == OP_POST) begin
                add_posting(doc, imp);
            end else if (kind == OP_READ) begin
                if (list_len == 0) begin
                    w = '0;
                    w.last = 1'b1;
                    pending_ranks.insert(pending_ranks.size(), w);
                end else begin
                    n = (list_len > MAX_OUT) ? MAX_OUT : list_len;
                    for (int k = 0; k < n; k++) begin
                        w.rank = RANK_W'(k);
                        w.doc = list_doc[k];
                        w.score = list_score[k];
                        w.filled = 1'b1;
                        w.last = (k + 1 == n);
                        pending_ranks.insert(pending_ranks.size(), w);
                    end
                end
            end
        endfunction

        task report(string what, int unsigned got_v, int unsigned want_v);
            mismatch_count++;
            if (mismatch_count <= 20) begin
                $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what,
                         got_v, want_v);
            end
        endtask

        task check_ranked_word(t_ranked_word got);
            t_ranked_word want;
            if (pending_ranks.size() == 0) begin
                report("unexpected ranking word, rank", got.rank, 0);
                return;
            end
            want = pending_ranks.pop_front();
            if (got.rank != want.rank) report("rank", got.rank, want.rank);
            if (got.doc != want.doc) report("ranked_doc", got.doc, want.doc);
            if (got.score != want.score) report("ranked_score", got.score, want.score);
            if (got.filled != want.filled) report("entry_valid", got.filled, want.filled);
            if (got.last != want.last) report("last", got.last, want.last);
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [KIND_W-1:0]  kind = '0;
    logic [DOC_W-1:0]   doc_id = '0;
    logic [IMP_W-1:0]   impact = '0;
    logic               out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [RANK_W-1:0]  o_rank;
    logic [DOC_W-1:0]   o_ranked_doc;
    logic [SCORE_W-1:0] o_ranked_score;
    logic               o_entry_valid;
    logic               o_last;

    ranking_scoreboard board = new();
    bit   calm_tail = 1'b0;
    bit   pressure_armed = 1'b0;
    bit   pressure_done = 1'b0;
    int   fed_words = 0;
    int   idle_cycles = 0;

    wire in_fire = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    impact_score_topk_accumulator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (kind),
        .i_doc_id       (doc_id),
        .i_impact       (impact),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_rank         (o_rank),
        .o_ranked_doc   (o_ranked_doc),
        .o_ranked_score (o_ranked_score),
        .o_entry_valid  (o_entry_valid),
        .o_last         (o_last)
    );

    always #10 clk = ~clk;

    // Offers one word, sometimes after a random gap, and waits for the edge that takes it.
    task automatic send_word(logic [KIND_W-1:0] k, logic [DOC_W-1:0] d,
                             logic [IMP_W-1:0] imp);
        int gap;
        if (!calm_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        doc_id <= d;
        impact <= imp;
        do @(posedge clk); while (o_in_stall);
        board.absorb_word(k, d, imp);
        if (k != KIND_UNUSED) begin
            fed_words++;
        end
    endtask

    task automatic run_query();
        logic [DOC_W-1:0] base;
        int span;
        int n;
        logic [IMP_W-1:0] imp;
        base = DOC_W'($urandom);
        span = $urandom_range(3, 24);
        n = $urandom_range(1, 40);
        if ($urandom_range(0, 4) != 0) begin
            send_word(OP_CLEAR, DOC_W'($urandom), IMP_W'($urandom));
        end
        for (int i = 0; i < n; i++) begin
            // Small impacts make equal scores, and so ties, common.
            imp = $urandom_range(0, 1) ? IMP_W'($urandom) : IMP_W'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) begin
                send_word(OP_READ, DOC_W'($urandom), IMP_W'($urandom));
            end else begin
                send_word(OP_POST, base ^ DOC_W'($urandom_range(0, span - 1)), imp);
            end
        end
        send_word(OP_READ, DOC_W'($urandom), IMP_W'($urandom));
    endtask

    initial begin
        int start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, zero and full impacts, ties, and a listed document re-placed behind equal scores.
        send_word(OP_READ, '0, '0);
        send_word(OP_CLEAR, 16'hFFFF, 8'hFF);
        send_word(OP_READ, '0, '0);
        send_word(OP_POST, 16'h0000, 8'h00);
        send_word(OP_POST, 16'hFFFF, 8'hFF);
        send_word(OP_POST, 16'h5AA5, 8'hFF);
        send_word(OP_POST, 16'h0000, 8'hFF);
        send_word(OP_READ, '0, '0);
        send_word(KIND_UNUSED, 16'hFFFF, 8'hFF);
        // Overfill the list; equal scores past the end are turned away.
        for (int i = 0; i < 14; i++) begin
            send_word(OP_POST, DOC_W'(100 + i), 8'd200);
        end
        send_word(OP_POST, 16'd200, 8'd201);
        // Document 110 now holds the last place and climbs from there.
        send_word(OP_POST, 16'd110, 8'd1);
        send_word(OP_READ, '0, '0);

        // Build one document up from several full impacts beside a small one.
        send_word(OP_CLEAR, '0, '0);
        for (int i = 0; i < 4; i++) begin
            send_word(OP_POST, 16'h8001, 8'hFF);
        end
        send_word(OP_POST, 16'h7FFE, 8'h01);
        send_word(OP_READ, '0, '0);

        start = fed_words;
        pressure_armed = 1'b1;
        while (fed_words < start + RANDOM_WORDS) begin
            if (fed_words >= start + CALM_WORDS) begin
                calm_tail = 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
                send_word(KIND_W'($urandom), DOC_W'($urandom), IMP_W'($urandom));
            end else begin
                run_query();
            end
        end
        in_valid <= 1'b0;

        while (board.pending_ranks.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        int burst;
        t_ranked_word got;
        burst = 0;
        forever begin
            @(posedge clk);
            if (out_fire) begin
                got.rank = o_rank;
                got.doc = o_ranked_doc;
                got.score = o_ranked_score;
                got.filled = o_entry_valid;
                got.last = o_last;
                board.check_ranked_word(got);
            end
            // One long hold-off so that the output register and the queue fill up.
            if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                out_stall <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (in_fire || out_fire) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
